[rtl/sstf_pkg.sv]
package sstf_pkg;

  // Fixed field widths of the request, result and configuration ports and of the arrival counter
  localparam int unsigned REQ_ID_W  = 4;
  localparam int unsigned LIMIT_W   = 5;
  localparam int unsigned COUNT_W   = 5;
  localparam int unsigned AGE_W     = 32;

  localparam logic [LIMIT_W-1:0] LIMIT_RESET = 5'd16;

  // Request types
  localparam logic REQ_INSERT  = 1'b0;
  localparam logic REQ_SERVICE = 1'b1;

  typedef enum logic [1:0] {
    STS_OK    = 2'd0,
    STS_FULL  = 2'd1,
    STS_BUSY  = 2'd2,
    STS_EMPTY = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_INS_SCAN,
    ST_SRV_SCAN,
    ST_SRV_LAST,
    ST_SRV_COMMIT,
    ST_DONE
  } state_t;

endpackage

[rtl/sstf_disk_request_scheduler.sv]
// Sequence: a refused insert or a service on an empty queue goes straight to ST_DONE; an insert
//   first walks the valid bits from slot 0 to the lowest free slot; a service first scans all
//   QUEUE_DEPTH slots, reading one slot per cycle from the slot memory, then commits the best.
// Throughput: one transaction at a time; the next is taken the cycle after the result is loaded.
// Reset (rst_n, synchronous, active low): queue empty, no requester outstanding, last track
//   and arrival counter zero, queue_limit 16; slot memory contents are not cleared.
module sstf_disk_request_scheduler
  import sstf_pkg::*;
#(
  parameter int unsigned QUEUE_DEPTH    = 16,
  parameter int unsigned NUM_REQUESTERS = 16,
  parameter int unsigned TRACK_WIDTH    = 16
) (
  input  logic                   clk,
  input  logic                   rst_n,
  // configuration
  input  logic                   cfg_wr_en,
  input  logic [LIMIT_W-1:0]     cfg_wr_data,
  // request channel
  input  logic                   in_valid,
  output logic                   in_stall,
  input  logic                   in_req_type,
  input  logic [REQ_ID_W-1:0]    in_requester_id,
  input  logic [TRACK_WIDTH-1:0] in_track,
  // result channel
  output logic                   out_valid,
  input  logic                   out_stall,
  output logic [1:0]             out_status,
  output logic [REQ_ID_W-1:0]    out_served_requester,
  output logic [TRACK_WIDTH-1:0] out_served_track,
  output logic [COUNT_W-1:0]     out_pending_count
);

  localparam int unsigned IDX_W   = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned CNT_W   = $clog2(QUEUE_DEPTH + 1);
  localparam int unsigned CMP_W   = (CNT_W > LIMIT_W) ? CNT_W : LIMIT_W;
  localparam int unsigned RID_W   = (NUM_REQUESTERS > 1) ? $clog2(NUM_REQUESTERS) : 1;
  localparam int unsigned ID_SPAN = 2 ** REQ_ID_W;
  localparam logic [IDX_W-1:0] LAST_IDX  = IDX_W'(QUEUE_DEPTH - 1);
  localparam logic [CMP_W-1:0] DEPTH_CMP = CMP_W'(QUEUE_DEPTH);

  // Control state
  state_t                    state_r, state_nxt;
  logic [LIMIT_W-1:0]        cfg_limit_r, cfg_limit_nxt;
  logic [QUEUE_DEPTH-1:0]    valid_r, valid_nxt;
  logic [NUM_REQUESTERS-1:0] outstanding_r, outstanding_nxt;
  logic [CNT_W-1:0]          count_r, count_nxt;
  logic [AGE_W-1:0]          arrival_r, arrival_nxt;
  logic [TRACK_WIDTH-1:0]    last_track_r, last_track_nxt;
  logic [IDX_W-1:0]          scan_idx_r, scan_idx_nxt;
  logic                      eval_en_r, eval_en_nxt;
  logic [IDX_W-1:0]          eval_idx_r, eval_idx_nxt;
  logic                      best_found_r, best_found_nxt;
  logic                      out_valid_r, out_valid_nxt;

  // Payload state
  logic [RID_W-1:0]          rid_r, rid_nxt;
  logic [TRACK_WIDTH-1:0]    track_r, track_nxt;
  logic [IDX_W-1:0]          best_idx_r, best_idx_nxt;
  logic [TRACK_WIDTH-1:0]    best_dist_r, best_dist_nxt;
  logic [AGE_W-1:0]          best_old_r, best_old_nxt;
  logic [REQ_ID_W-1:0]       best_req_r, best_req_nxt;
  logic [TRACK_WIDTH-1:0]    best_track_r, best_track_nxt;
  status_t                   res_status_r, res_status_nxt;
  logic [REQ_ID_W-1:0]       res_req_r, res_req_nxt;
  logic [TRACK_WIDTH-1:0]    res_track_r, res_track_nxt;
  status_t                   out_status_r, out_status_nxt;
  logic [REQ_ID_W-1:0]       out_req_r, out_req_nxt;
  logic [TRACK_WIDTH-1:0]    out_track_r, out_track_nxt;
  logic [COUNT_W-1:0]        out_count_r, out_count_nxt;

  // Slot memory: one write port, one registered read port
  logic [TRACK_WIDTH-1:0]    slot_track_mem [QUEUE_DEPTH];
  logic [REQ_ID_W-1:0]       slot_req_mem   [QUEUE_DEPTH];
  logic [AGE_W-1:0]          slot_age_mem   [QUEUE_DEPTH];
  logic                      mem_we;
  logic [IDX_W-1:0]          mem_waddr;
  logic [TRACK_WIDTH-1:0]    rd_track_r;
  logic [REQ_ID_W-1:0]       rd_req_r;
  logic [AGE_W-1:0]          rd_age_r;

  // Requester id reduction table
  logic [RID_W-1:0]          id_tab [ID_SPAN];
  logic [RID_W-1:0]          rid_in;

  // Shared compare unit
  logic [TRACK_WIDTH-1:0]    seek_dist;
  logic [AGE_W-1:0]          old_age;
  logic                      take;
  logic [CMP_W-1:0]          limit_eff;
  logic                      queue_full;

  for (genvar g = 0; g < ID_SPAN; g++) begin : g_id_tab
    assign id_tab[g] = RID_W'(g % NUM_REQUESTERS);
  end

  assign rid_in = id_tab[in_requester_id];

  // Effective limit, capped at the queue depth
  assign limit_eff  = (CMP_W'(cfg_limit_r) > DEPTH_CMP) ? DEPTH_CMP : CMP_W'(cfg_limit_r);
  assign queue_full = (CMP_W'(count_r) >= limit_eff);

  // Evaluate the slot read last cycle against the current best
  assign seek_dist = (rd_track_r >= last_track_r) ? (rd_track_r - last_track_r)
                                                  : (last_track_r - rd_track_r);
  assign old_age   = arrival_r - rd_age_r;
  assign take      = eval_en_r && valid_r[eval_idx_r] &&
                     (!best_found_r || (seek_dist < best_dist_r) ||
                      ((seek_dist == best_dist_r) && (old_age > best_old_r)));

  // Next state and datapath control
  always_comb begin
    state_nxt       = state_r;
    cfg_limit_nxt   = cfg_limit_r;
    valid_nxt       = valid_r;
    outstanding_nxt = outstanding_r;
    count_nxt       = count_r;
    arrival_nxt     = arrival_r;
    last_track_nxt  = last_track_r;
    scan_idx_nxt    = scan_idx_r;
    eval_en_nxt     = (state_r == ST_SRV_SCAN);
    eval_idx_nxt    = scan_idx_r;
    best_found_nxt  = best_found_r;
    out_valid_nxt   = out_valid_r;
    rid_nxt         = rid_r;
    track_nxt       = track_r;
    best_idx_nxt    = best_idx_r;
    best_dist_nxt   = best_dist_r;
    best_old_nxt    = best_old_r;
    best_req_nxt    = best_req_r;
    best_track_nxt  = best_track_r;
    res_status_nxt  = res_status_r;
    res_req_nxt     = res_req_r;
    res_track_nxt   = res_track_r;
    out_status_nxt  = out_status_r;
    out_req_nxt     = out_req_r;
    out_track_nxt   = out_track_r;
    out_count_nxt   = out_count_r;
    mem_we          = 1'b0;
    mem_waddr       = scan_idx_r;

    if (cfg_wr_en) begin
      cfg_limit_nxt = cfg_wr_data;
    end

    // Drop the result once the consumer takes it
    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end

    // Keep the nearest, then oldest, slot seen so far
    if (take) begin
      best_found_nxt = 1'b1;
      best_idx_nxt   = eval_idx_r;
      best_dist_nxt  = seek_dist;
      best_old_nxt   = old_age;
      best_req_nxt   = rd_req_r;
      best_track_nxt = rd_track_r;
    end

    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          rid_nxt        = rid_in;
          track_nxt      = in_track;
          best_found_nxt = 1'b0;
          scan_idx_nxt   = '0;
          res_req_nxt    = '0;
          res_track_nxt  = '0;
          if (in_req_type == REQ_INSERT) begin
            if (queue_full) begin
              res_status_nxt = STS_FULL;
              state_nxt      = ST_DONE;
            end else if (outstanding_r[rid_in]) begin
              res_status_nxt = STS_BUSY;
              state_nxt      = ST_DONE;
            end else begin
              state_nxt = ST_INS_SCAN;
            end
          end else begin
            if (count_r == '0) begin
              res_status_nxt = STS_EMPTY;
              state_nxt      = ST_DONE;
            end else begin
              state_nxt = ST_SRV_SCAN;
            end
          end
        end
      end

      // Walk to the lowest free slot and fill it
      ST_INS_SCAN: begin
        if (!valid_r[scan_idx_r]) begin
          mem_we                 = 1'b1;
          valid_nxt[scan_idx_r]  = 1'b1;
          outstanding_nxt[rid_r] = 1'b1;
          arrival_nxt            = arrival_r + 1'b1;
          count_nxt              = count_r + 1'b1;
          res_status_nxt         = STS_OK;
          state_nxt              = ST_DONE;
        end else begin
          scan_idx_nxt = scan_idx_r + 1'b1;
        end
      end

      // Issue one slot read per cycle
      ST_SRV_SCAN: begin
        if (scan_idx_r == LAST_IDX) begin
          state_nxt = ST_SRV_LAST;
        end else begin
          scan_idx_nxt = scan_idx_r + 1'b1;
        end
      end

      // Last slot is evaluated this cycle
      ST_SRV_LAST: begin
        state_nxt = ST_SRV_COMMIT;
      end

      // Retire the chosen slot
      ST_SRV_COMMIT: begin
        valid_nxt[best_idx_r]                = 1'b0;
        outstanding_nxt[RID_W'(best_req_r)]  = 1'b0;
        last_track_nxt                       = best_track_r;
        count_nxt                            = count_r - 1'b1;
        res_status_nxt                       = STS_OK;
        res_req_nxt                          = best_req_r;
        res_track_nxt                        = best_track_r;
        state_nxt                            = ST_DONE;
      end

      // Hold until the output register is free
      ST_DONE: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = res_status_r;
          out_req_nxt    = res_req_r;
          out_track_nxt  = res_track_r;
          out_count_nxt  = COUNT_W'(count_r);
          state_nxt      = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= ST_IDLE;
      cfg_limit_r   <= LIMIT_RESET;
      valid_r       <= '0;
      outstanding_r <= '0;
      count_r       <= '0;
      arrival_r     <= '0;
      last_track_r  <= '0;
      scan_idx_r    <= '0;
      eval_en_r     <= 1'b0;
      eval_idx_r    <= '0;
      best_found_r  <= 1'b0;
      out_valid_r   <= 1'b0;
    end else begin
      state_r       <= state_nxt;
      cfg_limit_r   <= cfg_limit_nxt;
      valid_r       <= valid_nxt;
      outstanding_r <= outstanding_nxt;
      count_r       <= count_nxt;
      arrival_r     <= arrival_nxt;
      last_track_r  <= last_track_nxt;
      scan_idx_r    <= scan_idx_nxt;
      eval_en_r     <= eval_en_nxt;
      eval_idx_r    <= eval_idx_nxt;
      best_found_r  <= best_found_nxt;
      out_valid_r   <= out_valid_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    rid_r        <= rid_nxt;
    track_r      <= track_nxt;
    best_idx_r   <= best_idx_nxt;
    best_dist_r  <= best_dist_nxt;
    best_old_r   <= best_old_nxt;
    best_req_r   <= best_req_nxt;
    best_track_r <= best_track_nxt;
    res_status_r <= res_status_nxt;
    res_req_r    <= res_req_nxt;
    res_track_r  <= res_track_nxt;
    out_status_r <= out_status_nxt;
    out_req_r    <= out_req_nxt;
    out_track_r  <= out_track_nxt;
    out_count_r  <= out_count_nxt;
  end

  // Slot memory write
  always_ff @(posedge clk) begin
    if (mem_we) begin
      slot_track_mem[mem_waddr] <= track_r;
      slot_req_mem[mem_waddr]   <= REQ_ID_W'(rid_r);
      slot_age_mem[mem_waddr]   <= arrival_r;
    end
  end

  // Slot memory read
  always_ff @(posedge clk) begin
    rd_track_r <= slot_track_mem[scan_idx_r];
    rd_req_r   <= slot_req_mem[scan_idx_r];
    rd_age_r   <= slot_age_mem[scan_idx_r];
  end

  assign in_stall             = (state_r != ST_IDLE);
  assign out_valid            = out_valid_r;
  assign out_status           = out_status_r;
  assign out_served_requester = out_req_r;
  assign out_served_track     = out_track_r;
  assign out_pending_count    = out_count_r;

endmodule

[rtl/sstf_chk.sv]
module sstf_chk
  import sstf_pkg::*;
#(
  parameter int unsigned QUEUE_DEPTH = 16,
  parameter int unsigned TRACK_WIDTH = 16
) (
  input logic                   clk,
  input logic                   rst_n,
  input logic                   out_valid,
  input logic                   out_stall,
  input logic [1:0]             out_status,
  input logic [REQ_ID_W-1:0]    out_served_requester,
  input logic [TRACK_WIDTH-1:0] out_served_track,
  input logic [COUNT_W-1:0]     out_pending_count
);

  // No result right after reset
  a_reset_idle: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid after reset");

  // A valid result's pending count never exceeds the queue depth (checked for depths up to 31)
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ((QUEUE_DEPTH > 31) || (out_pending_count <= QUEUE_DEPTH)))
    else $error("pending count above queue depth");

  // An empty-queue refusal reports zero pending
  a_empty_count: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_status == STS_EMPTY)) |-> (out_pending_count == '0))
    else $error("empty status with pending requests");

  // Refusals carry no served request
  a_refused_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_status != STS_OK)) |->
      ((out_served_requester == '0) && (out_served_track == '0)))
    else $error("refused transaction carries served fields");

  // Stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=>
      (out_valid && $stable(out_status) && $stable(out_served_requester) &&
       $stable(out_served_track) && $stable(out_pending_count)))
    else $error("stalled result changed");

endmodule

bind sstf_disk_request_scheduler sstf_chk #(
  .QUEUE_DEPTH(QUEUE_DEPTH),
  .TRACK_WIDTH(TRACK_WIDTH)
) u_sstf_chk (.*);
